@@ design/dclw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the draw command list walker.
// No dependencies; used by dclw_step and draw_command_list_walker.
package dclw_pkg;

	localparam int FETCH_BITS   = 19;
	localparam int TABLE_STRIDE = 32'h20;
	localparam int CTRL_END_BIT  = 15;
	localparam int CTRL_SKIP_BIT = 14;
	localparam int CTRL_JUMP_HI  = 13;
	localparam int CTRL_JUMP_LO  = 12;
	localparam int CTRL_CODE_HI  = 3;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_COMMAND = 1'b1;

	localparam logic [15:0] COUNT_MAX          = 16'hFFFF;
	localparam logic [15:0] TRIGGER_MODE_RESET = 16'd0;
	localparam logic        DISPLAY_EN_RESET   = 1'b1;
	localparam logic [15:0] CMD_LIMIT_RESET    = 16'd2000;

	typedef enum logic [1:0] {
		CFG_TRIGGER_MODE   = 2'd0,
		CFG_DISPLAY_ENABLE = 2'd1,
		CFG_COMMAND_LIMIT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		JUMP_NEXT   = 2'd0,
		JUMP_ASSIGN = 2'd1,
		JUMP_CALL   = 2'd2,
		JUMP_RETURN = 2'd3
	} jump_t;

	typedef enum logic [3:0] {
		KIND_NONE      = 4'd0,
		KIND_SPRITE    = 4'd1,
		KIND_SCALED    = 4'd2,
		KIND_DISTORTED = 4'd3,
		KIND_POLYGON   = 4'd4,
		KIND_POLYLINE  = 4'd5,
		KIND_LINE      = 4'd6,
		KIND_USER_CLIP = 4'd7,
		KIND_SYS_CLIP  = 4'd8,
		KIND_LOCAL     = 4'd9,
		KIND_BAD       = 4'd10
	} kind_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] control_word;
		logic [15:0] link_word;
	} cmd_t;

	typedef struct packed {
		logic [3:0]            dispatch_kind;
		logic [FETCH_BITS-1:0] fetch_address;
		logic                  walk_active;
		logic                  finished;
		logic [1:0]            end_status;
	} res_t;

	typedef struct packed {
		logic [15:0] trigger_mode;
		logic        display_enable;
		logic [15:0] command_limit;
	} cfg_t;

	typedef struct packed {
		logic       walking;
		logic       return_valid;
		logic [1:0] status_bits;
	} walk_flags_t;

	function automatic kind_t kind_of_code(input logic [3:0] code);
		kind_t k;
		unique case (code)
			4'h0: k = KIND_SPRITE;
			4'h1: k = KIND_SCALED;
			4'h2: k = KIND_DISTORTED;
			4'h4: k = KIND_POLYGON;
			4'h5: k = KIND_POLYLINE;
			4'h6: k = KIND_LINE;
			4'h8: k = KIND_USER_CLIP;
			4'h9: k = KIND_SYS_CLIP;
			4'hA: k = KIND_LOCAL;
			default: k = KIND_BAD;
		endcase
		return k;
	endfunction

endpackage

@@ design/dclw_step.sv @@
`timescale 1ns / 1ps
// Decode of one start or command word and the next walker state.
// Depends on dclw_pkg.
module dclw_step #(
	parameter int ADDR_BITS = 19
) (
	input  dclw_pkg::cmd_t        cmd,
	input  dclw_pkg::cfg_t        cfg,
	input  logic [ADDR_BITS-1:0]  table_addr,
	input  logic [ADDR_BITS-1:0]  ret_addr,
	input  logic [15:0]           count,
	input  dclw_pkg::walk_flags_t flags,
	output logic [ADDR_BITS-1:0]  table_addr_nx,
	output logic [ADDR_BITS-1:0]  ret_addr_nx,
	output logic [15:0]           count_nx,
	output dclw_pkg::walk_flags_t flags_nx,
	output dclw_pkg::res_t        res
);

	localparam int EXT_BITS = (ADDR_BITS > dclw_pkg::FETCH_BITS) ? ADDR_BITS
		: dclw_pkg::FETCH_BITS;

	logic [ADDR_BITS-1:0] seq_addr;
	logic [ADDR_BITS-1:0] link_addr;
	logic [EXT_BITS-1:0]  ext_addr;
	dclw_pkg::jump_t      jump;

	assign seq_addr  = table_addr + ADDR_BITS'(dclw_pkg::TABLE_STRIDE);
	assign link_addr = ADDR_BITS'({cmd.link_word, 3'b000});
	assign jump      = dclw_pkg::jump_t'(
		cmd.control_word[dclw_pkg::CTRL_JUMP_HI:dclw_pkg::CTRL_JUMP_LO]);

	always_comb begin
		table_addr_nx     = table_addr;
		ret_addr_nx       = ret_addr;
		count_nx          = count;
		flags_nx          = flags;
		res.dispatch_kind = dclw_pkg::KIND_NONE;
		res.finished      = 1'b0;
		if (cmd.operation == dclw_pkg::OP_START) begin
			// restart; a refused start leaves the end status alone
			table_addr_nx         = '0;
			ret_addr_nx           = '0;
			count_nx              = '0;
			flags_nx.return_valid = 1'b0;
			if (cfg.trigger_mode == '0 || !cfg.display_enable) begin
				flags_nx.walking = 1'b0;
			end else begin
				flags_nx.walking     = 1'b1;
				flags_nx.status_bits = {1'b0, flags.status_bits[1]};
			end
		end else if (flags.walking) begin
			if (cmd.control_word[dclw_pkg::CTRL_END_BIT] || count >= cfg.command_limit) begin
				flags_nx.walking        = 1'b0;
				flags_nx.status_bits[1] = 1'b1;
				res.finished            = 1'b1;
			end else begin
				if (!cmd.control_word[dclw_pkg::CTRL_SKIP_BIT]) begin
					res.dispatch_kind = dclw_pkg::kind_of_code(
						cmd.control_word[dclw_pkg::CTRL_CODE_HI:0]);
				end
				unique case (jump)
					dclw_pkg::JUMP_NEXT: begin
						table_addr_nx = seq_addr;
					end
					dclw_pkg::JUMP_ASSIGN: begin
						table_addr_nx = link_addr;
					end
					dclw_pkg::JUMP_CALL: begin
						// one level only: keep the first return address
						if (!flags.return_valid) begin
							ret_addr_nx           = seq_addr;
							flags_nx.return_valid = 1'b1;
						end
						table_addr_nx = link_addr;
					end
					dclw_pkg::JUMP_RETURN: begin
						if (flags.return_valid) begin
							table_addr_nx         = ret_addr;
							flags_nx.return_valid = 1'b0;
						end else begin
							table_addr_nx = seq_addr;
						end
					end
					default: begin
						table_addr_nx = seq_addr;
					end
				endcase
				if (count != dclw_pkg::COUNT_MAX) begin
					count_nx = count + 16'd1;
				end
			end
		end
		ext_addr          = EXT_BITS'(table_addr_nx);
		res.fetch_address = ext_addr[dclw_pkg::FETCH_BITS-1:0];
		res.walk_active   = flags_nx.walking;
		res.end_status    = flags_nx.status_bits;
	end

endmodule

@@ design/draw_command_list_walker.sv @@
`timescale 1ns / 1ps
// Top level of the draw command list walker: word registers, walker state,
// configuration registers. Depends on dclw_pkg and dclw_step.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  cmd     | in        | cmd_valid / cmd_ready | cmd  (dclw_pkg::cmd_t)
//  res     | out       | res_valid / res_ready | res  (dclw_pkg::res_t)
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index (2 b), cfg_data (16 b)
//
// One word per cycle sustained while the result register is not stalled. A
// word is held in the input register, decoded against the walker state, and
// its result lands in the output register.
// The walker state is updated in the same cycle as the decode, so the next word
// sees it at once. A stalled result register holds the input register, which
// then drops cmd_ready. Reset clears the walker state and loads the register
// defaults (trigger mode 0, display on, limit 2000). cfg_ready is always high.
module draw_command_list_walker #(
	parameter int ADDR_BITS = 19
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  dclw_pkg::cmd_t    cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output dclw_pkg::res_t    res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	// input register
	logic           valid_s1;
	dclw_pkg::cmd_t cmd_s1;

	// output register
	logic           res_valid_q;
	dclw_pkg::res_t res_q;

	// configuration
	dclw_pkg::cfg_t cfg_q;

	// walker state
	logic [ADDR_BITS-1:0]  table_addr_q;
	logic [ADDR_BITS-1:0]  ret_addr_q;
	logic [15:0]           count_q;
	dclw_pkg::walk_flags_t flags_q;

	logic [ADDR_BITS-1:0]  table_addr_nx;
	logic [ADDR_BITS-1:0]  ret_addr_nx;
	logic [15:0]           count_nx;
	dclw_pkg::walk_flags_t flags_nx;
	dclw_pkg::res_t        res_nx;

	logic fire;

	// decode the held word once the result register has room
	assign fire      = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || fire;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

	dclw_step #(
		.ADDR_BITS(ADDR_BITS)
	) u_step (
		.cmd          (cmd_s1),
		.cfg          (cfg_q),
		.table_addr   (table_addr_q),
		.ret_addr     (ret_addr_q),
		.count        (count_q),
		.flags        (flags_q),
		.table_addr_nx(table_addr_nx),
		.ret_addr_nx  (ret_addr_nx),
		.count_nx     (count_nx),
		.flags_nx     (flags_nx),
		.res          (res_nx)
	);

	// control and walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
			table_addr_q <= '0;
			ret_addr_q   <= '0;
			count_q      <= '0;
			flags_q      <= '0;
		end else begin
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (fire) begin
				res_valid_q  <= 1'b1;
				table_addr_q <= table_addr_nx;
				ret_addr_q   <= ret_addr_nx;
				count_q      <= count_nx;
				flags_q      <= flags_nx;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
		if (fire) begin
			res_q <= res_nx;
		end
	end

	// configuration registers; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_mode   <= dclw_pkg::TRIGGER_MODE_RESET;
			cfg_q.display_enable <= dclw_pkg::DISPLAY_EN_RESET;
			cfg_q.command_limit  <= dclw_pkg::CMD_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dclw_pkg::cfg_reg_t'(cfg_index))
				dclw_pkg::CFG_TRIGGER_MODE: begin
					cfg_q.trigger_mode <= cfg_data;
				end
				dclw_pkg::CFG_DISPLAY_ENABLE: begin
					cfg_q.display_enable <= cfg_data[0];
				end
				dclw_pkg::CFG_COMMAND_LIMIT: begin
					cfg_q.command_limit <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTH
	// a finishing word stops the walk and marks the current frame ended
	a_finish_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_nx.finished |=> !flags_q.walking && flags_q.status_bits[1])
		else $error("walk still active after a finishing word");

	// a start word restarts the walk at table zero with a clear count
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd_s1.operation == dclw_pkg::OP_START |=>
			table_addr_q == '0 && count_q == '0 && !flags_q.return_valid)
		else $error("start word did not clear walker state");

	// a held word with a stalled result must block new input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !res_ready |-> !cmd_ready)
		else $error("input accepted while the pipeline is stalled");

	// the walker state moves only when a word is decoded
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(table_addr_q) && $stable(count_q))
		else $error("walker state changed without a decoded word");
`endif

endmodule
